### design/cbf_pkg.sv
// shared types and constants for the cubic curve flattener
// no dependencies
package cbf_pkg;

  localparam int FIELD_W         = 24;
  localparam int TOL_W           = 16;
  localparam int BUDGET_W        = 7;
  localparam int CFG_W           = 16;
  localparam int CFG_IDX_W       = 1;
  localparam int STACK_DEPTH_DEF = 32;
  localparam int COORD_FRAC_DEF  = 8;
  localparam int SCALE_BASE      = 8;

  localparam logic [TOL_W-1:0]    TOL_RESET    = TOL_W'(128);
  localparam logic [BUDGET_W-1:0] BUDGET_RESET = BUDGET_W'(64);
  localparam logic [BUDGET_W-1:0] BUDGET_MIN   = BUDGET_W'(2);
  localparam logic [BUDGET_W-1:0] BUDGET_MAX   = BUDGET_W'(64);

  localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_BUDGET    = 1'b1;

  typedef struct packed {
    logic signed [FIELD_W-1:0] start_x;
    logic signed [FIELD_W-1:0] start_y;
    logic signed [FIELD_W-1:0] ctrl_a_x;
    logic signed [FIELD_W-1:0] ctrl_a_y;
    logic signed [FIELD_W-1:0] ctrl_b_x;
    logic signed [FIELD_W-1:0] ctrl_b_y;
    logic signed [FIELD_W-1:0] finish_x;
    logic signed [FIELD_W-1:0] finish_y;
  } item_t;

  typedef struct packed {
    logic signed [FIELD_W-1:0] point_x;
    logic signed [FIELD_W-1:0] point_y;
    logic                      last_point;
    logic                      truncated;
  } point_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_START, ST_TEST, ST_MUL, ST_DECIDE, ST_SPLIT, ST_POP, ST_RELOAD
  } state_t;

endpackage

### design/cbf_ram.sv
// generic single write port ram with registered read
// no dependencies
module cbf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### design/cbf_fifo.sv
// two entry queue used on both sides of the flattening engine
// depends on nothing but its parameter
module cbf_fifo #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             rd,
  output logic [WIDTH-1:0] rdata,
  output logic             full,
  output logic             empty
);

  logic [WIDTH-1:0] mem_r [2];
  logic             wp_r, rp_r;
  logic [1:0]       cnt_r;
  logic             do_wr, do_rd;

  assign full  = (cnt_r == 2'd2);
  assign empty = (cnt_r == 2'd0);
  assign do_wr = wr && !full;
  assign do_rd = rd && !empty;
  assign rdata = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wp_r] <= wdata;
    end
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (do_wr) wp_r <= !wp_r;
      if (do_rd) rp_r <= !rp_r;
      cnt_r <= cnt_r + 2'(do_wr) - 2'(do_rd);
    end
  end

endmodule

### design/cbf_back.sv
// flattening engine: curve stack sequencer, flatness test and midpoint split
// depends on cbf_pkg and cbf_ram
module cbf_back import cbf_pkg::*; #(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF,
  parameter int COORD_FRAC  = COORD_FRAC_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  item_t               in_item,
  output logic                in_take,
  input  logic [TOL_W-1:0]    tol,
  input  logic [BUDGET_W-1:0] budget,
  input  logic                out_full,
  output logic                emit_valid,
  output point_t              emit
);

  localparam int CW   = FIELD_W + COORD_FRAC;
  localparam int AW   = $clog2(STACK_DEPTH);
  localparam int PW   = 2 * CW + 2;
  localparam int TW   = PW + 1;
  localparam int DW   = PW + 2;
  localparam int CMPW = 2 * CW + 32;
  localparam int SB   = SCALE_BASE + COORD_FRAC;
  localparam logic [CW+1:0] S_VAL   = (CW+2)'(1) << SB;
  localparam logic [AW-1:0] TOP_MAX = AW'(STACK_DEPTH - 1);

  state_t state_r, state_nxt;
  logic signed [CW-1:0] cur_r [8];
  logic signed [CW-1:0] cur_nxt [8];
  logic signed [CW-1:0] fst [8];
  logic signed [CW-1:0] sec [8];
  logic signed [FIELD_W-1:0] finx_r, finy_r, finx_nxt, finy_nxt;
  logic [AW-1:0]       top_r, top_nxt;
  logic [BUDGET_W-1:0] pts_r, pts_nxt;
  logic [2:0]          cnt_r, cnt_nxt;
  logic signed [PW-1:0] prod_r, prod_nxt;
  logic signed [TW-1:0] t_r, t_nxt, t_diff;
  logic [DW-1:0]        d_r, d_nxt;
  logic [CMPW-1:0]      rhs_r, rhs_nxt;
  logic signed [CW:0]   dx, dy, e13, e02, e15, e04, mul_a, mul_b;
  logic [CW:0]          adx, ady;
  logic [CW+1:0]        len;
  logic [CW+2:0]        dshort;
  logic                 long_c, flat;
  logic [CMPW-1:0]      lhs, rhs;
  logic [BUDGET_W-1:0]  bud;
  logic                 ram_we;
  logic [AW-1:0]        ram_raddr;
  logic [8*CW-1:0]      ram_wdata, ram_rdata;

  function automatic logic [CW:0] mag(input logic signed [CW:0] v);
    mag = v[CW] ? (CW+1)'(-v) : (CW+1)'(v);
  endfunction

  function automatic logic signed [CW-1:0] avg(input logic signed [CW-1:0] a,
                                                input logic signed [CW-1:0] b);
    logic signed [CW:0] s;
    s = (CW+1)'(a) + (CW+1)'(b);
    avg = s[CW:1];
  endfunction

  assign bud = (budget < BUDGET_MIN) ? BUDGET_MIN :
               (budget > BUDGET_MAX) ? BUDGET_MAX : budget;

  // chord and control offsets of the current curve
  assign dx  = (CW+1)'(cur_r[6]) - (CW+1)'(cur_r[0]);
  assign dy  = (CW+1)'(cur_r[7]) - (CW+1)'(cur_r[1]);
  assign e13 = (CW+1)'(cur_r[1]) - (CW+1)'(cur_r[3]);
  assign e02 = (CW+1)'(cur_r[0]) - (CW+1)'(cur_r[2]);
  assign e15 = (CW+1)'(cur_r[1]) - (CW+1)'(cur_r[5]);
  assign e04 = (CW+1)'(cur_r[0]) - (CW+1)'(cur_r[4]);
  assign adx = mag(dx);
  assign ady = mag(dy);
  assign len = (CW+2)'(adx) + (CW+2)'(ady);
  assign long_c = (len > S_VAL);
  assign dshort = (CW+3)'(mag(e02)) + (CW+3)'(mag(e13)) + (CW+3)'(mag(e04))
                + (CW+3)'(mag(e15));

  assign mul_a = cnt_r[0] ? dy : dx;
  always_comb begin
    case (cnt_r[1:0])
      2'd0:    mul_b = e13;
      2'd1:    mul_b = e02;
      2'd2:    mul_b = e15;
      default: mul_b = e04;
    endcase
  end

  assign t_diff = t_r - TW'(prod_r);
  assign lhs  = long_c ? (CMPW'(d_r) << SCALE_BASE) : (CMPW'(dshort) << SCALE_BASE);
  assign rhs  = long_c ? rhs_r : (CMPW'(tol) << SB);
  assign flat = (lhs < rhs);

  // de casteljau halves, x and y independently
  always_comb begin
    logic signed [CW-1:0] c, f2, s3, f3, s2, m;
    for (int k = 0; k < 2; k++) begin
      c  = avg(cur_r[2+k], cur_r[4+k]);
      f2 = avg(cur_r[k], cur_r[2+k]);
      s3 = avg(cur_r[4+k], cur_r[6+k]);
      f3 = avg(f2, c);
      s2 = avg(s3, c);
      m  = avg(f3, s2);
      fst[k] = cur_r[k]; fst[2+k] = f2; fst[4+k] = f3; fst[6+k] = m;
      sec[k] = m;        sec[2+k] = s2; sec[4+k] = s3; sec[6+k] = cur_r[6+k];
    end
  end

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      ram_wdata[i*CW +: CW] = sec[i];
    end
  end

  cbf_ram #(.WIDTH(8 * CW), .DEPTH(STACK_DEPTH)) u_stack (
    .clk   (clk),
    .we    (ram_we),
    .waddr (top_r),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_nxt  = state_r;
    cur_nxt    = cur_r;
    finx_nxt   = finx_r;
    finy_nxt   = finy_r;
    top_nxt    = top_r;
    pts_nxt    = pts_r;
    cnt_nxt    = cnt_r;
    prod_nxt   = prod_r;
    t_nxt      = t_r;
    d_nxt      = d_r;
    rhs_nxt    = rhs_r;
    in_take    = 1'b0;
    emit_valid = 1'b0;
    emit       = '0;
    ram_we     = 1'b0;
    ram_raddr  = top_r - AW'(1);
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          in_take = 1'b1;
          cur_nxt[0] = CW'(in_item.start_x)  <<< COORD_FRAC;
          cur_nxt[1] = CW'(in_item.start_y)  <<< COORD_FRAC;
          cur_nxt[2] = CW'(in_item.ctrl_a_x) <<< COORD_FRAC;
          cur_nxt[3] = CW'(in_item.ctrl_a_y) <<< COORD_FRAC;
          cur_nxt[4] = CW'(in_item.ctrl_b_x) <<< COORD_FRAC;
          cur_nxt[5] = CW'(in_item.ctrl_b_y) <<< COORD_FRAC;
          cur_nxt[6] = CW'(in_item.finish_x) <<< COORD_FRAC;
          cur_nxt[7] = CW'(in_item.finish_y) <<< COORD_FRAC;
          finx_nxt  = in_item.finish_x;
          finy_nxt  = in_item.finish_y;
          top_nxt   = '0;
          pts_nxt   = BUDGET_W'(1);
          state_nxt = ST_START;
        end
      end
      ST_START: begin
        if (!out_full) begin
          emit_valid = 1'b1;
          emit.point_x = FIELD_W'(cur_r[0] >>> COORD_FRAC);
          emit.point_y = FIELD_W'(cur_r[1] >>> COORD_FRAC);
          state_nxt = ST_TEST;
        end
      end
      ST_TEST: begin
        cnt_nxt = '0;
        d_nxt   = '0;
        state_nxt = (top_r == TOP_MAX) ? ST_POP : ST_MUL;
      end
      ST_MUL: begin
        if (cnt_r == 3'd0) begin
          rhs_nxt = CMPW'(tol) * CMPW'(len) << SB;
        end
        if (cnt_r != 3'd4) begin
          prod_nxt = PW'(mul_a) * PW'(mul_b);
        end
        case (cnt_r)
          3'd1, 3'd3: t_nxt = TW'(prod_r);
          3'd2, 3'd4: d_nxt = d_r + (t_diff[TW-1] ? DW'(-t_diff) : DW'(t_diff));
          default: ;
        endcase
        cnt_nxt = cnt_r + 3'd1;
        if (cnt_r == 3'd4) state_nxt = ST_DECIDE;
      end
      ST_DECIDE: begin
        state_nxt = flat ? ST_POP : ST_SPLIT;
      end
      ST_SPLIT: begin
        ram_we  = 1'b1;
        cur_nxt = fst;
        top_nxt = top_r + AW'(1);
        state_nxt = ST_TEST;
      end
      ST_POP: begin
        if (!out_full) begin
          emit_valid = 1'b1;
          pts_nxt = pts_r + BUDGET_W'(1);
          if (top_r == '0) begin
            emit.point_x = FIELD_W'(cur_r[6] >>> COORD_FRAC);
            emit.point_y = FIELD_W'(cur_r[7] >>> COORD_FRAC);
            emit.last_point = 1'b1;
            state_nxt = ST_IDLE;
          end else if ((pts_r + BUDGET_W'(1)) >= bud) begin
            emit.point_x = finx_r;
            emit.point_y = finy_r;
            emit.last_point = 1'b1;
            emit.truncated  = 1'b1;
            top_nxt = '0;
            state_nxt = ST_IDLE;
          end else begin
            emit.point_x = FIELD_W'(cur_r[6] >>> COORD_FRAC);
            emit.point_y = FIELD_W'(cur_r[7] >>> COORD_FRAC);
            top_nxt = top_r - AW'(1);
            state_nxt = ST_RELOAD;
          end
        end
      end
      ST_RELOAD: begin
        for (int i = 0; i < 8; i++) begin
          cur_nxt[i] = ram_rdata[i*CW +: CW];
        end
        state_nxt = ST_TEST;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      top_r   <= '0;
      pts_r   <= '0;
    end else begin
      state_r <= state_nxt;
      top_r   <= top_nxt;
      pts_r   <= pts_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r  <= cur_nxt;
    finx_r <= finx_nxt;
    finy_r <= finy_nxt;
    cnt_r  <= cnt_nxt;
    prod_r <= prod_nxt;
    t_r    <= t_nxt;
    d_r    <= d_nxt;
    rhs_r  <= rhs_nxt;
  end

  a_no_emit_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    emit_valid |-> !out_full) else $error("emit while result queue full");
  a_split_below_top: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SPLIT |-> top_r != TOP_MAX) else $error("split on full stack");
  a_reload_follows_pop: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_RELOAD |-> $past(state_r) == ST_POP && $past(top_r) == top_r + AW'(1))
    else $error("reload without pop");
  a_take_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_take |-> state_r == ST_IDLE && in_valid) else $error("take while busy");

endmodule

### design/cubic_bezier_flattener.sv
// top level of the cubic curve flattener: config registers, queues, engine
// depends on cbf_pkg, cbf_fifo, cbf_back (and cbf_ram through it)
//
// channel  direction  handshake           payload
// input    in         push / full         in_start_x .. in_finish_y
// result   out        pop / empty         out_point_x, out_point_y, out_last_point, out_truncated
// config   in         cfg_we              cfg_index, cfg_data
//
// each refinement step runs test, four products and a drain, and decision,
// then a split or a pop with the stack reload
// a 64 point curve takes about 127 steps; the shared multiplier in the
// flatness test sets the step length
// reset is synchronous active low; the curve stack needs no clearing
// a full result queue stalls the engine at the next emitted point only

module cubic_bezier_flattener import cbf_pkg::*; #(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF,
  parameter int COORD_FRAC  = COORD_FRAC_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      push,
  output logic                      full,
  input  logic signed [FIELD_W-1:0] in_start_x,
  input  logic signed [FIELD_W-1:0] in_start_y,
  input  logic signed [FIELD_W-1:0] in_ctrl_a_x,
  input  logic signed [FIELD_W-1:0] in_ctrl_a_y,
  input  logic signed [FIELD_W-1:0] in_ctrl_b_x,
  input  logic signed [FIELD_W-1:0] in_ctrl_b_y,
  input  logic signed [FIELD_W-1:0] in_finish_x,
  input  logic signed [FIELD_W-1:0] in_finish_y,
  input  logic                      pop,
  output logic                      empty,
  output logic signed [FIELD_W-1:0] out_point_x,
  output logic signed [FIELD_W-1:0] out_point_y,
  output logic                      out_last_point,
  output logic                      out_truncated,
  input  logic                      cfg_we,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [CFG_W-1:0]          cfg_data
);

  logic [TOL_W-1:0]    tol_r;
  logic [BUDGET_W-1:0] budget_r;
  item_t  in_item, q_item;
  point_t emit, res;
  logic   iq_empty, take, emit_valid, oq_full;

  // configuration registers; the user must write them only while idle, the block itself does not enforce it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r    <= TOL_RESET;
      budget_r <= BUDGET_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_TOLERANCE: tol_r    <= cfg_data;
        REG_BUDGET:    budget_r <= cfg_data[BUDGET_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_item = '{start_x: in_start_x, start_y: in_start_y,
                     ctrl_a_x: in_ctrl_a_x, ctrl_a_y: in_ctrl_a_y,
                     ctrl_b_x: in_ctrl_b_x, ctrl_b_y: in_ctrl_b_y,
                     finish_x: in_finish_x, finish_y: in_finish_y};

  // front: queue of accepted curves
  cbf_fifo #(.WIDTH($bits(item_t))) u_inq (
    .clk   (clk),
    .rst_n (rst_n),
    .wr    (push),
    .wdata (in_item),
    .rd    (take),
    .rdata (q_item),
    .full  (full),
    .empty (iq_empty)
  );

  // back: subdivision engine
  cbf_back #(.STACK_DEPTH(STACK_DEPTH), .COORD_FRAC(COORD_FRAC)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (!iq_empty),
    .in_item    (q_item),
    .in_take    (take),
    .tol        (tol_r),
    .budget     (budget_r),
    .out_full   (oq_full),
    .emit_valid (emit_valid),
    .emit       (emit)
  );

  // result queue decouples the engine from the consumer
  cbf_fifo #(.WIDTH($bits(point_t))) u_outq (
    .clk   (clk),
    .rst_n (rst_n),
    .wr    (emit_valid),
    .wdata (emit),
    .rd    (pop),
    .rdata (res),
    .full  (oq_full),
    .empty (empty)
  );

  assign out_point_x    = res.point_x;
  assign out_point_y    = res.point_y;
  assign out_last_point = res.last_point;
  assign out_truncated  = res.truncated;

endmodule
